// File: rtl/pcpe_pkg.sv
package pcpe_pkg;

  localparam int TRIG_BITS = 16;
  localparam int TRIG_W = TRIG_BITS + 2;
  localparam int HORNER_STEPS = 6;
  localparam int SC_STAGES = 15;
  localparam int ANGLE_W = 24;
  localparam int RND_W = 41;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

  localparam logic [5:0] SIN_K [HORNER_STEPS] = '{6'd38, 6'd37, 6'd37, 6'd36, 6'd35, 6'd33};
  localparam logic [5:0] COS_K [HORNER_STEPS] = '{6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd31};

  localparam logic [31:0] SIN_M [HORNER_STEPS] = '{
    32'(((64'd1 << 38) + 64'd155) / 64'd156),
    32'(((64'd1 << 37) + 64'd109) / 64'd110),
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam logic [31:0] COS_M [HORNER_STEPS] = '{
    32'(((64'd1 << 38) + 64'd131) / 64'd132),
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12),
    32'(((64'd1 << 31) + 64'd1) / 64'd2)
  };

  typedef enum logic [1:0] {
    CURVE_CIRCLE  = 2'd0,
    CURVE_ELLIPSE = 2'd1,
    CURVE_HELIX   = 2'd2
  } curve_kind_t;

  typedef enum logic [2:0] {
    REG_CURVE_KIND = 3'd0,
    REG_RADIUS_X   = 3'd1,
    REG_RADIUS_Y   = 3'd2,
    REG_PITCH      = 3'd3,
    REG_CENTER_X   = 3'd4,
    REG_CENTER_Y   = 3'd5,
    REG_CENTER_Z   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         curve_kind;
    logic [30:0]        radius_x;
    logic [30:0]        radius_y;
    logic signed [31:0] pitch;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                 quad;
    logic                       swap;
    logic signed [ANGLE_W-1:0]  angle;
  } sc_meta_t;

  // Divide by 2^sh, rounding half away from zero.
  function automatic logic signed [63:0] rnd_away(input logic signed [63:0] p,
                                                  input int unsigned sh);
    logic signed [63:0] half;
    half = 64'sd1 <<< (sh - 1);
    if (p[63]) begin
      return (p + half - 64'sd1) >>> sh;
    end
    return (p + half) >>> sh;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// File: rtl/pcpe_cfg.sv
module pcpe_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output pcpe_pkg::cfg_t    cfg
);
  import pcpe_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.curve_kind <= CURVE_CIRCLE;
      cfg_r.radius_x   <= 31'd65536;
      cfg_r.radius_y   <= 31'd65536;
      cfg_r.pitch      <= 32'sd65536;
      cfg_r.center_x   <= '0;
      cfg_r.center_y   <= '0;
      cfg_r.center_z   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CURVE_KIND: cfg_r.curve_kind <= cfg_data[1:0];
        REG_RADIUS_X: begin
          if (cfg_data[30:0] != 31'd0) begin
            cfg_r.radius_x <= cfg_data[30:0];
          end
        end
        REG_RADIUS_Y: begin
          if (cfg_data[30:0] != 31'd0) begin
            cfg_r.radius_y <= cfg_data[30:0];
          end
        end
        REG_PITCH:    cfg_r.pitch    <= cfg_data;
        REG_CENTER_X: cfg_r.center_x <= cfg_data;
        REG_CENTER_Y: cfg_r.center_y <= cfg_data;
        REG_CENTER_Z: cfg_r.center_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/pcpe_sincos.sv
module pcpe_sincos (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic signed [pcpe_pkg::ANGLE_W-1:0]   in_angle,
  output logic                                  out_valid,
  output logic signed [pcpe_pkg::ANGLE_W-1:0]   out_angle,
  output logic signed [pcpe_pkg::TRIG_W-1:0]    out_sin,
  output logic signed [pcpe_pkg::TRIG_W-1:0]    out_cos
);
  import pcpe_pkg::*;

  logic                 valid_r [SC_STAGES];
  sc_meta_t             meta_r  [SC_STAGES];
  logic [29:0]          r_r     [13];
  logic [29:0]          x2_r    [1:10];
  logic [61:0]          qs_r    [HORNER_STEPS];
  logic [61:0]          qc_r    [HORNER_STEPS];
  logic [60:0]          ps_r    [HORNER_STEPS-1];
  logic [60:0]          pc_r    [HORNER_STEPS-1];
  logic [60:0]          sp_r;
  logic [30:0]          tc_r;
  logic signed [TRIG_W-1:0] sin_r;
  logic signed [TRIG_W-1:0] cos_r;

  logic [13:0]  w;
  logic         swap;
  logic [13:0]  wf;
  logic [46:0]  wprod;
  logic [60:0]  rsq;
  sc_meta_t     meta_in;

  always_comb begin
    w     = in_angle[13:0];
    swap  = w > 14'h2000;
    wf    = swap ? 14'(15'h4000 - {1'b0, w}) : w;
    wprod = 47'(wf) * 47'(TWO_PI_Q30) + 47'h8000;
    rsq   = 61'(r_r[0]) * 61'(r_r[0]) + 61'h2000_0000;
    meta_in.quad  = in_angle[15:14];
    meta_in.swap  = swap;
    meta_in.angle = in_angle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SC_STAGES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      valid_r[0] <= in_valid;
      for (int i = 1; i < SC_STAGES; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= meta_in;
    for (int i = 1; i < SC_STAGES; i++) begin
      meta_r[i] <= meta_r[i-1];
    end
    r_r[0] <= wprod[45:16];
    for (int i = 1; i < 13; i++) begin
      r_r[i] <= r_r[i-1];
    end
    x2_r[1] <= rsq[59:30];
    for (int i = 2; i <= 10; i++) begin
      x2_r[i] <= x2_r[i-1];
    end
    qs_r[0] <= 62'(x2_r[1]) * 62'(SIN_M[0]);
    qc_r[0] <= 62'(x2_r[1]) * 62'(COS_M[0]);
  end

  for (genvar j = 1; j < HORNER_STEPS; j++) begin : g_horner
    logic [30:0] ts;
    logic [30:0] tc;
    always_comb begin
      ts = ONE_Q30 - {1'b0, 30'(qs_r[j-1] >> SIN_K[j-1])};
      tc = ONE_Q30 - {1'b0, 30'(qc_r[j-1] >> COS_K[j-1])};
    end
    always_ff @(posedge clk) begin
      ps_r[j-1] <= 61'(x2_r[2*j]) * 61'(ts);
      pc_r[j-1] <= 61'(x2_r[2*j]) * 61'(tc);
      qs_r[j]   <= 62'(ps_r[j-1][59:30]) * 62'(SIN_M[j]);
      qc_r[j]   <= 62'(pc_r[j-1][59:30]) * 62'(COS_M[j]);
    end
  end

  logic [30:0] ts_last;
  logic [31:0] ssum;
  logic [31:0] csum;
  logic [TRIG_BITS:0] s_mag;
  logic [TRIG_BITS:0] c_mag;
  logic signed [TRIG_W-1:0] s_pos;
  logic signed [TRIG_W-1:0] c_pos;
  logic signed [TRIG_W-1:0] sin_nxt;
  logic signed [TRIG_W-1:0] cos_nxt;

  always_comb begin
    ts_last = ONE_Q30 - {1'b0, 30'(qs_r[HORNER_STEPS-1] >> SIN_K[HORNER_STEPS-1])};
    ssum  = {1'b0, sp_r[60:30]} + (32'd1 << (29 - TRIG_BITS));
    csum  = {1'b0, tc_r} + (32'd1 << (29 - TRIG_BITS));
    s_mag = ssum[30-TRIG_BITS +: TRIG_BITS+1];
    c_mag = csum[30-TRIG_BITS +: TRIG_BITS+1];
    if (meta_r[13].swap) begin
      s_pos = signed'({1'b0, c_mag});
      c_pos = signed'({1'b0, s_mag});
    end else begin
      s_pos = signed'({1'b0, s_mag});
      c_pos = signed'({1'b0, c_mag});
    end
    case (meta_r[13].quad)
      2'd0: begin
        sin_nxt = s_pos;
        cos_nxt = c_pos;
      end
      2'd1: begin
        sin_nxt = c_pos;
        cos_nxt = -s_pos;
      end
      2'd2: begin
        sin_nxt = -s_pos;
        cos_nxt = -c_pos;
      end
      default: begin
        sin_nxt = -c_pos;
        cos_nxt = s_pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sp_r  <= 61'(r_r[12]) * 61'(ts_last);
    tc_r  <= ONE_Q30 - {1'b0, 30'(qc_r[HORNER_STEPS-1] >> COS_K[HORNER_STEPS-1])};
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  assign out_valid = valid_r[SC_STAGES-1];
  assign out_angle = meta_r[SC_STAGES-1].angle;
  assign out_sin   = sin_r;
  assign out_cos   = cos_r;

endmodule

// File: rtl/pcpe_out.sv
module pcpe_out (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pcpe_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  input  logic signed [pcpe_pkg::ANGLE_W-1:0]  in_angle,
  input  logic signed [pcpe_pkg::TRIG_W-1:0]   in_sin,
  input  logic signed [pcpe_pkg::TRIG_W-1:0]   in_cos,
  output logic                                 out_valid,
  output logic signed [31:0]                   out_point_x,
  output logic signed [31:0]                   out_point_y,
  output logic signed [31:0]                   out_point_z,
  output logic signed [31:0]                   out_deriv_x,
  output logic signed [31:0]                   out_deriv_y,
  output logic signed [31:0]                   out_deriv_z
);
  import pcpe_pkg::*;

  localparam int PW = 32 + TRIG_W;

  logic signed [31:0] rx;
  logic signed [31:0] ry;
  logic helix;

  always_comb begin
    rx    = signed'({1'b0, cfg.radius_x});
    ry    = (cfg.curve_kind == CURVE_ELLIPSE) ? signed'({1'b0, cfg.radius_y}) : rx;
    helix = cfg.curve_kind == CURVE_HELIX;
  end

  logic va_r, vb_r, vc_r;
  logic signed [PW-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [55:0]   pz_r;
  logic signed [62:0]   pd_r;

  logic signed [RND_W-1:0] rxc_r, rys_r, rxs_r, ryc_r, rz_r, rd_r;

  logic signed [31:0] px_r, py_r, pzo_r, dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    pxc_r <= PW'(rx) * PW'(in_cos);
    pys_r <= PW'(ry) * PW'(in_sin);
    pxs_r <= PW'(rx) * PW'(in_sin);
    pyc_r <= PW'(ry) * PW'(in_cos);
    pz_r  <= 56'(cfg.pitch) * 56'(in_angle);
    pd_r  <= 63'(cfg.pitch) * 63'(signed'({1'b0, INV_TWO_PI_Q32}));

    rxc_r <= RND_W'(rnd_away(64'(pxc_r), TRIG_BITS));
    rys_r <= RND_W'(rnd_away(64'(pys_r), TRIG_BITS));
    rxs_r <= RND_W'(rnd_away(64'(pxs_r), TRIG_BITS));
    ryc_r <= RND_W'(rnd_away(64'(pyc_r), TRIG_BITS));
    rz_r  <= RND_W'(rnd_away(64'(pz_r), 16));
    rd_r  <= RND_W'(rnd_away(64'(pd_r), 32));

    px_r  <= sat32(64'(cfg.center_x) + 64'(rxc_r));
    py_r  <= sat32(64'(cfg.center_y) + 64'(rys_r));
    dx_r  <= sat32(-64'(rxs_r));
    dy_r  <= sat32(64'(ryc_r));
    pzo_r <= helix ? sat32(64'(cfg.center_z) + 64'(rz_r)) : cfg.center_z;
    dz_r  <= helix ? sat32(64'(rd_r)) : 32'sd0;
  end

  assign out_valid   = vc_r;
  assign out_point_x = px_r;
  assign out_point_y = py_r;
  assign out_point_z = pzo_r;
  assign out_deriv_x = dx_r;
  assign out_deriv_y = dy_r;
  assign out_deriv_z = dz_r;

endmodule

// File: rtl/parametric_curve_point_eval_core.sv
// Point and derivative generator for a circle, an ellipse or a helix.
// Configuration is written through cfg_we, cfg_index and cfg_data while no
// word is in flight; a radius write of zero is ignored.
// An input word (in_angle_turns, signed Q8.16 turns) is taken at every clock
// edge with start high and busy low. Busy is high only during reset, so a new
// word can be taken in every cycle.
// Each word gives one result word, shown for exactly one cycle with out_valid
// high, once the pipeline below has carried it through. The pipeline is 15 register
// stages of sine and cosine (angle fold, square, six Horner steps each with a
// multiply and a reciprocal multiply, finish) and 3 stages of scaling,
// rounding and saturation. Throughput is one word per cycle.
// Synchronous reset empties the pipeline and restores the register defaults:
// circle, both radii and pitch 1.0, center at the origin.
// The receiver cannot stall; results are not held.
module parametric_curve_point_eval_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] in_angle_turns,
  output logic               out_valid,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic signed [31:0] out_deriv_x,
  output logic signed [31:0] out_deriv_y,
  output logic signed [31:0] out_deriv_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pcpe_pkg::*;

  logic busy_r;
  logic accept;
  cfg_t cfg;
  logic sc_valid;
  logic signed [ANGLE_W-1:0] sc_angle;
  logic signed [TRIG_W-1:0]  sc_sin;
  logic signed [TRIG_W-1:0]  sc_cos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  pcpe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcpe_sincos u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_angle  (in_angle_turns),
    .out_valid (sc_valid),
    .out_angle (sc_angle),
    .out_sin   (sc_sin),
    .out_cos   (sc_cos)
  );

  pcpe_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (sc_valid),
    .in_angle    (sc_angle),
    .in_sin      (sc_sin),
    .in_cos      (sc_cos),
    .out_valid   (out_valid),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y),
    .out_point_z (out_point_z),
    .out_deriv_x (out_deriv_x),
    .out_deriv_y (out_deriv_y),
    .out_deriv_z (out_deriv_z)
  );

endmodule

// File: tb/parametric_curve_point_eval_core_test.sv
`timescale 1ns / 1ps

module parametric_curve_point_eval_core_test;
  import pcpe_pkg::*;

  typedef logic [0:5][31:0] point_word_t;

  typedef struct packed {
    logic [23:0] angle;
    logic        fixed;
    point_word_t word;
  } sweep_row_t;

  typedef struct packed {
    logic        fixed;
    point_word_t word;
  } pending_t;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 25;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS = 60;

  // Reset state is a unit circle at the origin, so the quadrant points are exact.
  localparam sweep_row_t SWEEP [14] = '{
    '{24'h000000, 1'b1, '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0}},
    '{24'h004000, 1'b1, '{32'h0, 32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0}},
    '{24'h008000, 1'b1, '{32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0}},
    '{24'h00C000, 1'b1, '{32'h0, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0}},
    '{24'h002000, 1'b0, '0},
    '{24'h001FFF, 1'b0, '0},
    '{24'h002001, 1'b0, '0},
    '{24'h003FFF, 1'b0, '0},
    '{24'h000001, 1'b0, '0},
    '{24'h7FFFFF, 1'b0, '0},
    '{24'h800000, 1'b0, '0},
    '{24'hFFFFFF, 1'b0, '0},
    '{24'h555555, 1'b0, '0},
    '{24'hAAAAAA, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [23:0] in_angle_turns = '0;
  logic               out_valid;
  logic signed [31:0] out_point_x, out_point_y, out_point_z;
  logic signed [31:0] out_deriv_x, out_deriv_y, out_deriv_z;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  logic [1:0]         m_kind;
  longint             m_rx, m_ry;
  logic signed [31:0] m_pitch, m_cx, m_cy, m_cz;

  pending_t    pending_q[$];
  point_word_t point_q[$];
  int          n_taken = 0;
  int          n_checked = 0;
  int          n_errors = 0;
  int          burst_left = 0;

  always #10 clk = ~clk;

  parametric_curve_point_eval_core u_top (
    .clk, .rst_n, .start, .busy, .in_angle_turns, .out_valid,
    .out_point_x, .out_point_y, .out_point_z,
    .out_deriv_x, .out_deriv_y, .out_deriv_z,
    .cfg_we, .cfg_index, .cfg_data
  );

  function automatic longint div_away(longint p, int sh);
    longint mag;
    mag = (p < 0) ? -p : p;
    mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
    return (p < 0) ? -mag : mag;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint series(longint x2, bit odd);
    longint t;
    longint dv [6];
    if (odd) dv = '{156, 110, 72, 42, 20, 6};
    else dv = '{132, 90, 56, 30, 12, 2};
    t = 64'sd1 <<< 30;
    for (int i = 0; i < 6; i++) begin
      t = (64'sd1 <<< 30) - (((x2 * t) >>> 30) / dv[i]);
    end
    return t;
  endfunction

  function automatic point_word_t curve_point(logic [23:0] angle);
    point_word_t res;
    logic [1:0] quad;
    longint w, r, x2, s, c, tmp, sn, cs, ry, pz, dz;
    quad = angle[15:14];
    w = longint'(angle[13:0]);
    r = 0;
    if (w > 64'sd8192) begin
      w = 64'sd16384 - w;
    end
    r = (w * 64'sd6746518852 + (64'sd1 <<< 15)) >>> 16;
    x2 = (r * r + (64'sd1 <<< 29)) >>> 30;
    s = ((r * series(x2, 1'b1)) >>> 30);
    c = series(x2, 1'b0);
    s = (s + (64'sd1 <<< 13)) >>> 14;
    c = (c + (64'sd1 <<< 13)) >>> 14;
    if (longint'(angle[13:0]) > 64'sd8192) begin
      tmp = s;
      s = c;
      c = tmp;
    end
    case (quad)
      2'd0: begin sn = s; cs = c; end
      2'd1: begin sn = c; cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
    ry = (m_kind == CURVE_ELLIPSE) ? m_ry : m_rx;
    pz = longint'(m_cz);
    dz = 0;
    if (m_kind == CURVE_HELIX) begin
      pz = pz + div_away(longint'(m_pitch) * longint'($signed(angle)), 16);
      dz = div_away(longint'(m_pitch) * 64'sd683565276, 32);
    end
    res[0] = clamp32(longint'(m_cx) + div_away(m_rx * cs, TRIG_BITS));
    res[1] = clamp32(longint'(m_cy) + div_away(ry * sn, TRIG_BITS));
    res[2] = clamp32(pz);
    res[3] = clamp32(-div_away(m_rx * sn, TRIG_BITS));
    res[4] = clamp32(div_away(ry * cs, TRIG_BITS));
    res[5] = clamp32(dz);
    return res;
  endfunction

  always @(posedge clk) begin
    point_word_t got, want;
    pending_t    pend;
    string       names [6];
    names = '{"point_x", "point_y", "point_z", "deriv_x", "deriv_y", "deriv_z"};
    if (rst_n && out_valid) begin
      got = {out_point_x, out_point_y, out_point_z, out_deriv_x, out_deriv_y, out_deriv_z};
      if (point_q.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        n_errors++;
      end else begin
        want = point_q.pop_front();
        n_checked++;
        for (int i = 0; i < 6; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: %s expected %h actual %h", $time, names[i], want[i], got[i]);
            n_errors++;
          end
        end
      end
    end
    if (rst_n && start && !busy) begin
      pend = pending_q.pop_front();
      point_q.push_back(pend.fixed ? pend.word : curve_point(in_angle_turns));
      n_taken++;
    end
  end

  task automatic send_angle(logic [23:0] angle, logic fixed, point_word_t word);
    int seen;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    seen = n_taken;
    pending_q.push_back('{fixed, word});
    start <= 1'b1;
    in_angle_turns <= angle;
    do @(negedge clk); while (n_taken == seen);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (point_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_CURVE_KIND: m_kind = value[1:0];
      REG_RADIUS_X: if (value[30:0] != 0) m_rx = longint'(value[30:0]);
      REG_RADIUS_Y: if (value[30:0] != 0) m_ry = longint'(value[30:0]);
      REG_PITCH: m_pitch = value;
      REG_CENTER_X: m_cx = value;
      REG_CENTER_Y: m_cy = value;
      REG_CENTER_Z: m_cz = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word(int style);
    case (style)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0001;
      3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic configure(int phase);
    logic [31:0] radius;
    write_reg(REG_CURVE_KIND, (phase < 4) ? phase : $urandom);
    radius = (phase == 1) ? 32'h7FFF_FFFF : (phase == 2) ? 32'h0000_0001 :
             {1'b0, $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(1, 32'h00A0_0000))};
    write_reg(REG_RADIUS_X, radius);
    write_reg(REG_RADIUS_Y, (phase == 1) ? 32'h0000_0001 : pick_word(phase + 2) & 32'h7FFF_FFFF);
    write_reg(REG_RADIUS_X, (phase == 4) ? 32'h8000_0000 : 32'h0);
    write_reg(REG_PITCH, pick_word((phase == 3) ? 1 : (phase == 5) ? 0 : $urandom_range(2, 4)));
    write_reg(REG_CENTER_X, pick_word(phase % 5));
    write_reg(REG_CENTER_Y, pick_word((phase + 1) % 5));
    write_reg(REG_CENTER_Z, pick_word((phase + 3) % 5));
    write_reg(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [23:0] angle;
    m_kind = CURVE_CIRCLE;
    m_rx = 65536;
    m_ry = 65536;
    m_pitch = 32'sh0001_0000;
    m_cx = '0;
    m_cy = '0;
    m_cz = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (SWEEP[i]) begin
      send_angle(SWEEP[i].angle, SWEEP[i].fixed, SWEEP[i].word);
    end
    drain();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      configure(phase);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 5))
          0: angle = {8'($urandom), 2'($urandom), 14'h2000 + 14'($urandom_range(0, 2)) - 14'd1};
          1: angle = {8'($urandom), 2'($urandom), 14'($urandom_range(0, 2)) - 14'd1};
          default: angle = 24'($urandom);
        endcase
        send_angle(angle, 1'b0, '0);
      end
      drain();
    end
    $display("Checked %0d result words over %0d accepted angles and %0d curve settings.",
             n_checked, n_taken, RANDOM_PHASES + 1);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out waiting for result words.");
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: parametric_curve_point_eval_core.f
rtl/pcpe_pkg.sv
rtl/pcpe_cfg.sv
rtl/pcpe_sincos.sv
rtl/pcpe_out.sv
rtl/parametric_curve_point_eval_core.sv
tb/parametric_curve_point_eval_core_test.sv
